>>> sv/bblc_pkg.sv
// ----------------------------------------------------------------------------
// bblc_pkg
// Shared types and codes for the byte-budget result cache.
// ----------------------------------------------------------------------------
package bblc_pkg;

  localparam int unsigned OP_BITS    = 2;
  localparam int unsigned STAT_BITS  = 2;
  localparam int unsigned REC_BITS   = 48;
  localparam int unsigned BYTES_BITS = 32;
  localparam int unsigned GEN_BITS   = 32;
  localparam int unsigned CNT_BITS   = 5;
  localparam int unsigned IN_TAG_BITS = 16;
  localparam logic [31:0] BUDGET_RESET = 32'd16777216;

  typedef enum logic [OP_BITS-1:0] {
    OP_REQUEST  = 2'd0,
    OP_COMPLETE = 2'd1,
    OP_SNAPSHOT = 2'd2,
    OP_CANCEL   = 2'd3
  } opcode_e;

  typedef enum logic [STAT_BITS-1:0] {
    ST_ABSENT  = 2'd0,
    ST_PENDING = 2'd1,
    ST_READY   = 2'd2,
    ST_FAILED  = 2'd3
  } status_e;

  // scan kinds issued by the controller
  typedef enum logic [1:0] {
    SCAN_FIND   = 2'd0,
    SCAN_VICTIM = 2'd1,
    SCAN_READY  = 2'd2
  } scan_e;

  typedef struct packed {
    logic  start_scan;   // begin a slot sweep
    scan_e scan_kind;
    logic  do_op;        // apply the operation after find
    logic  do_evict;     // drop the found oldest ready slot
    logic  finish;       // compose the result word
  } ctrl_cmd_t;

  typedef struct packed {
    logic    scan_done;
    logic    need_evict; // complete: over budget with a ready victim
    logic    need_victim;// request: no hit and no free slot
  } ctrl_stat_t;

  typedef struct packed {
    logic [OP_BITS-1:0]     opcode;
    logic [IN_TAG_BITS-1:0] asset_tag;
    logic                   asset_present;
    logic [GEN_BITS-1:0]    job_generation;
    logic [BYTES_BITS-1:0]  result_bytes;
  } in_word_t;

  typedef struct packed {
    logic [STAT_BITS-1:0]  entry_status;
    logic                  job_issued;
    logic [GEN_BITS-1:0]   issued_generation;
    logic                  completion_dropped;
    logic [CNT_BITS-1:0]   entries_evicted;
    logic                  table_full;
    logic [BYTES_BITS-1:0] retained_total;
    logic [CNT_BITS-1:0]   pending_total;
  } out_word_t;

endpackage

>>> sv/bblc_if.sv
// ----------------------------------------------------------------------------
// bblc_in_if / bblc_out_if
// Valid/ready channels carrying the request and result words.
// ----------------------------------------------------------------------------
interface bblc_in_if;
  import bblc_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bblc_out_if;
  import bblc_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> sv/bblc_datapath.sv
// ----------------------------------------------------------------------------
// bblc_datapath
// Slot table, counters and a one-slot-per-cycle scanner.
// ----------------------------------------------------------------------------
module bblc_datapath #(
  parameter int unsigned TABLE_ENTRIES = 16,
  parameter int unsigned TAG_BITS      = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           load_i,
  input  bblc_pkg::in_word_t             in_i,
  input  logic [31:0]                    budget_i,
  input  bblc_pkg::ctrl_cmd_t            cmd_i,
  output bblc_pkg::ctrl_stat_t           stat_o,
  output bblc_pkg::out_word_t            res_o
);
  import bblc_pkg::*;

  localparam int unsigned IDX_BITS = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CTR_BITS = $clog2(TABLE_ENTRIES + 1);

  logic [TABLE_ENTRIES-1:0] valid_q;
  logic [TAG_BITS-1:0]      tag_q    [TABLE_ENTRIES];
  status_e                  status_q [TABLE_ENTRIES];
  logic [REC_BITS-1:0]      rec_q    [TABLE_ENTRIES];
  logic [BYTES_BITS-1:0]    bytes_q  [TABLE_ENTRIES];
  logic [GEN_BITS-1:0]      gen_q    [TABLE_ENTRIES];

  logic [REC_BITS-1:0]   use_q;
  logic [GEN_BITS-1:0]   cur_gen_q;
  logic [BYTES_BITS-1:0] retained_q;
  logic [CTR_BITS-1:0]   pend_q;

  in_word_t            w_q;
  logic [TAG_BITS-1:0] tag_w;

  // scanner state
  logic                busy_q;
  scan_e               kind_q;
  logic [IDX_BITS-1:0] idx_q;
  logic                hit_q, free_q, best_ok_q;
  logic [IDX_BITS-1:0] hit_idx_q, free_idx_q, best_q;
  logic [REC_BITS-1:0] best_rec_q;
  logic                done_q;

  // result fields
  logic                  issued_q, dropped_q, full_q;
  logic [GEN_BITS-1:0]   igen_q;
  logic [CNT_BITS-1:0]   evicted_q;
  logic [STAT_BITS-1:0]  stat_res_q;

  logic tag_nz, last, cand;

  always_comb begin
    tag_w  = TAG_BITS'(w_q.asset_tag);
    tag_nz = (tag_w != '0);
    last   = (idx_q == IDX_BITS'(TABLE_ENTRIES - 1));
    cand   = 1'b0;
    if (valid_q[idx_q] && !(hit_q && idx_q == hit_idx_q && kind_q == SCAN_READY)) begin
      if (kind_q == SCAN_READY) cand = (status_q[idx_q] == ST_READY);
      else                      cand = (status_q[idx_q] != ST_PENDING);
    end
  end

  // retained + bytes > budget, 33-bit compare
  logic over;
  assign over = ({1'b0, retained_q} + {1'b0, w_q.result_bytes}) > {1'b0, budget_i};

  logic [REC_BITS-1:0] tick;
  assign tick = use_q + REC_BITS'(1);

  logic stale;
  assign stale = (w_q.job_generation != cur_gen_q) || !tag_nz || !hit_q ||
                 (gen_q[hit_idx_q] != w_q.job_generation) ||
                 (status_q[hit_idx_q] != ST_PENDING);

  // evictions only for a live completion that fits the budget on its own
  always_comb begin
    stat_o.scan_done   = done_q;
    stat_o.need_evict  = (w_q.opcode == OP_COMPLETE) && over && best_ok_q && !stale &&
                         !(w_q.result_bytes > budget_i);
    stat_o.need_victim = (w_q.opcode == OP_REQUEST) && tag_nz && !hit_q && !free_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      use_q      <= '0;
      cur_gen_q  <= '0;
      retained_q <= '0;
      pend_q     <= '0;
      busy_q     <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      done_q <= busy_q && !cmd_i.start_scan && last;
      if (load_i) begin
        w_q       <= in_i;
        issued_q  <= 1'b0;
        dropped_q <= 1'b0;
        full_q    <= 1'b0;
        igen_q    <= '0;
        evicted_q <= '0;
      end
      if (cmd_i.start_scan) begin
        busy_q    <= 1'b1;
        kind_q    <= cmd_i.scan_kind;
        idx_q     <= '0;
        best_ok_q <= 1'b0;
        if (cmd_i.scan_kind == SCAN_FIND) begin
          hit_q  <= 1'b0;
          free_q <= 1'b0;
        end
      end else if (busy_q) begin
        if (kind_q == SCAN_FIND) begin
          if (valid_q[idx_q] && tag_q[idx_q] == tag_w && !hit_q) begin
            hit_q     <= 1'b1;
            hit_idx_q <= idx_q;
          end
          if (!valid_q[idx_q] && !free_q) begin
            free_q     <= 1'b1;
            free_idx_q <= idx_q;
          end
        end else if (cand && (!best_ok_q || rec_q[idx_q] < best_rec_q)) begin
          best_ok_q  <= 1'b1;
          best_q     <= idx_q;
          best_rec_q <= rec_q[idx_q];
        end
        idx_q <= idx_q + IDX_BITS'(1);
        if (last) begin
          busy_q <= 1'b0;
        end
      end

      if (cmd_i.do_evict) begin
        retained_q <= retained_q - bytes_q[best_q];
        valid_q[best_q] <= 1'b0;
        evicted_q <= evicted_q + CNT_BITS'(1);
      end

      if (cmd_i.do_op) begin
        case (opcode_e'(w_q.opcode))
          OP_REQUEST: begin
            if (tag_nz) begin
              if (hit_q && (status_q[hit_idx_q] == ST_PENDING ||
                            status_q[hit_idx_q] == ST_READY)) begin
                rec_q[hit_idx_q] <= tick;
                use_q <= tick;
              end else if (!hit_q && !free_q && !best_ok_q) begin
                full_q <= 1'b1;
              end else begin : alloc
                logic [IDX_BITS-1:0] s;
                logic [BYTES_BITS-1:0] ret;
                s   = hit_q ? hit_idx_q : (free_q ? free_idx_q : best_q);
                ret = retained_q;
                if (!hit_q && !free_q && status_q[s] == ST_READY) begin
                  ret = ret - bytes_q[s];
                  evicted_q <= CNT_BITS'(1);
                end
                retained_q <= ret;
                valid_q[s] <= 1'b1;
                tag_q[s]   <= tag_w;
                bytes_q[s] <= '0;
                rec_q[s]   <= tick;
                use_q      <= tick;
                gen_q[s]   <= cur_gen_q;
                hit_q      <= 1'b1;
                hit_idx_q  <= s;
                if (w_q.asset_present) begin
                  status_q[s] <= ST_PENDING;
                  pend_q      <= pend_q + CTR_BITS'(1);
                  issued_q    <= 1'b1;
                  igen_q      <= cur_gen_q;
                end else begin
                  status_q[s] <= ST_FAILED;
                end
              end
            end
          end
          OP_COMPLETE: begin
            if (stale) begin
              dropped_q <= 1'b1;
            end else begin
              rec_q[hit_idx_q] <= tick;
              use_q  <= tick;
              pend_q <= pend_q - CTR_BITS'(1);
              if (w_q.result_bytes > budget_i) begin
                status_q[hit_idx_q] <= ST_FAILED;
                bytes_q[hit_idx_q]  <= '0;
              end else begin
                status_q[hit_idx_q] <= ST_READY;
                bytes_q[hit_idx_q]  <= w_q.result_bytes;
                retained_q <= retained_q + w_q.result_bytes;
              end
            end
          end
          OP_SNAPSHOT: begin
            if (tag_nz && hit_q) begin
              rec_q[hit_idx_q] <= tick;
              use_q <= tick;
            end
          end
          OP_CANCEL: begin
            cur_gen_q  <= cur_gen_q + GEN_BITS'(1);
            valid_q    <= '0;
            retained_q <= '0;
            pend_q     <= '0;
          end
          default: ;
        endcase
      end

      if (cmd_i.finish) begin
        if (w_q.opcode != OP_CANCEL && tag_nz && hit_q && valid_q[hit_idx_q])
          stat_res_q <= status_q[hit_idx_q];
        else
          stat_res_q <= ST_ABSENT;
      end
    end
  end

  always_comb begin
    res_o.entry_status       = stat_res_q;
    res_o.job_issued         = issued_q;
    res_o.issued_generation  = igen_q;
    res_o.completion_dropped = dropped_q;
    res_o.entries_evicted    = evicted_q;
    res_o.table_full         = full_q;
    res_o.retained_total     = retained_q;
    res_o.pending_total      = CNT_BITS'(pend_q);
  end

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.start_scan |=> busy_q) else $error("scan did not start");
  a_evict_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.do_evict |-> best_ok_q && valid_q[best_q]) else $error("bad evict");
  a_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("double done");

endmodule

>>> sv/bblc_ctrl.sv
// ----------------------------------------------------------------------------
// bblc_ctrl
// Sequencer: find scan, optional victim or eviction scans, update, result.
// ----------------------------------------------------------------------------
module bblc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           opcode_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output bblc_pkg::ctrl_cmd_t  cmd_o,
  input  bblc_pkg::ctrl_stat_t stat_i
);
  import bblc_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_FIND   = 7'b0000010,
    S_VICT   = 7'b0000100,
    S_EVSCAN = 7'b0001000,
    S_EVDEC  = 7'b0010000,
    S_FIN    = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   is_complete_q;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: if (in_valid_i) begin
        state_d = S_FIND;
        cmd_o.start_scan = 1'b1;
        cmd_o.scan_kind  = SCAN_FIND;
      end
      S_FIND: if (stat_i.scan_done) begin
        if (is_complete_q) begin
          state_d = S_EVSCAN;
          cmd_o.start_scan = 1'b1;
          cmd_o.scan_kind  = SCAN_READY;
        end else if (stat_i.need_victim) begin
          state_d = S_VICT;
          cmd_o.start_scan = 1'b1;
          cmd_o.scan_kind  = SCAN_VICTIM;
        end else begin
          state_d = S_FIN;
          cmd_o.do_op = 1'b1;
        end
      end
      S_VICT: if (stat_i.scan_done) begin
        state_d = S_FIN;
        cmd_o.do_op = 1'b1;
      end
      S_EVSCAN: if (stat_i.scan_done) state_d = S_EVDEC;
      S_EVDEC: begin
        if (stat_i.need_evict) begin
          cmd_o.do_evict   = 1'b1;
          cmd_o.start_scan = 1'b1;
          cmd_o.scan_kind  = SCAN_READY;
          state_d = S_EVSCAN;
        end else begin
          cmd_o.do_op = 1'b1;
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        cmd_o.finish = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: if (out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      is_complete_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_IDLE && in_valid_i)
        is_complete_q <= (opcode_i == OP_COMPLETE);
    end
  end

  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_FIN)) else $error("bad out");
  a_evict_only_complete: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.do_evict |-> is_complete_q) else $error("evict outside complete");
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.do_op, cmd_o.do_evict, cmd_o.finish})) else $error("cmd clash");

endmodule

>>> sv/byte_budget_lru_result_cache_unit.sv
// ----------------------------------------------------------------------------
// byte_budget_lru_result_cache_unit
// Tagged result cache with LRU replacement under a byte budget.
// ----------------------------------------------------------------------------
// sequence: each accepted word runs a find scan, then its update and result; a
//   completion adds a ready scan plus another ready scan per eviction, and a
//   request needing a victim adds a victim scan
// handshake: one word at a time; a new word is accepted only back in idle
// reset: table empty, counters and generation zero, budget 16777216
module byte_budget_lru_result_cache_unit #(
  parameter int unsigned TABLE_ENTRIES = 16,
  parameter int unsigned TAG_BITS      = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  bblc_in_if.sink     in_if,
  bblc_out_if.source  out_if
);
  import bblc_pkg::*;

  logic [31:0] budget_q;
  ctrl_cmd_t   cmd;
  ctrl_stat_t  stat;
  logic        load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) budget_q <= BUDGET_RESET;
    else if (cfg_we_i) budget_q <= cfg_wdata_i;
  end

  assign load = in_if.valid && in_if.ready;

  bblc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .opcode_i    (in_if.data.opcode),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  bblc_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .TAG_BITS      (TAG_BITS)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (load),
    .in_i     (in_if.data),
    .budget_i (budget_q),
    .cmd_i    (cmd),
    .stat_o   (stat),
    .res_o    (out_if.data)
  );

endmodule
